### design/bts_pkg.sv
// shared types and constants of the ber-tlv tag search unit
package bts_pkg;

    localparam logic [7:0] LONG_LEN_MARK = 8'h81;
    localparam logic [7:0] TAG_MASK      = 8'h7F;
    localparam logic [8:0] TLV_HDR_LEN   = 9'd2;
    localparam logic [8:0] MAX9          = 9'h1FF;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_TAG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OCCURRENCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MERGE_MODE = 2'd2;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_TRUNCATED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        EV_SOM = 2'd0,
        EV_HDR = 2'd1,
        EV_NF  = 2'd2,
        EV_EOM = 2'd3
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t   kind;
        logic       eom;
        logic       last;
        logic [8:0] tlv_start;
        logic [6:0] tag;
        logic [8:0] size;
    } evt_t;

endpackage

### design/bts_front.sv
// byte parser: tracks message framing and turns tlv headers into events
module bts_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // data_byte
    input  logic          s_tlast,   // end_of_message
    input  logic          s_tuser,   // start_of_message
    input  logic          q_ready,
    output logic          push,
    output bts_pkg::evt_t push_evt
);

    typedef enum logic [6:0] {
        PH_IDLE       = 7'b0000001,
        PH_OUTER_LEN  = 7'b0000010,
        PH_OUTER_LEN2 = 7'b0000100,
        PH_TAG        = 7'b0001000,
        PH_LEN        = 7'b0010000,
        PH_LEN2       = 7'b0100000,
        PH_SKIP       = 7'b1000000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [8:0] pos_reg, pos_next;
    logic [7:0] outer_reg, outer_next;
    logic [7:0] consumed_reg, consumed_next;
    logic [8:0] start_reg, start_next;
    logic [6:0] tag_reg, tag_next;
    logic [7:0] skip_reg, skip_next;

    logic       accept;
    logic       take_outer;
    logic       hdr_go;
    logic [8:0] hdr_size;
    logic [9:0] hdr_sum;
    logic       hdr_last;

    assign s_tready = q_ready;
    assign accept   = s_tvalid && s_tready;

    assign take_outer = ((phase_reg == PH_OUTER_LEN) && (s_tdata != bts_pkg::LONG_LEN_MARK))
                        || (phase_reg == PH_OUTER_LEN2);
    assign hdr_go     = ((phase_reg == PH_LEN) && (s_tdata != bts_pkg::LONG_LEN_MARK))
                        || (phase_reg == PH_LEN2);
    assign hdr_size   = {1'b0, s_tdata} + bts_pkg::TLV_HDR_LEN
                        + {8'd0, (phase_reg == PH_LEN2)};
    assign hdr_sum    = {2'b00, consumed_reg} + {1'b0, hdr_size};
    assign hdr_last   = hdr_sum >= {2'b00, outer_reg};

    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        outer_next    = outer_reg;
        consumed_next = consumed_reg;
        start_next    = start_reg;
        tag_next      = tag_reg;
        skip_next     = skip_reg;
        push          = 1'b0;
        push_evt.kind      = bts_pkg::EV_EOM;
        push_evt.eom       = s_tlast;
        push_evt.last      = hdr_last;
        push_evt.tlv_start = start_reg;
        push_evt.tag       = tag_reg;
        push_evt.size      = hdr_size;

        if (accept) begin
            if (s_tuser) begin
                pos_next      = 9'd1;
                phase_next    = PH_OUTER_LEN;
                consumed_next = 8'd0;
                outer_next    = 8'd0;
                push_evt.kind = bts_pkg::EV_SOM;
                push          = 1'b1;
            end else begin
                if (pos_reg != bts_pkg::MAX9) begin
                    pos_next = pos_reg + 9'd1;
                end
                if (phase_reg != PH_IDLE) begin
                    push = s_tlast;
                end
                if (take_outer) begin
                    outer_next = s_tdata;
                    if (s_tdata == 8'd0) begin
                        phase_next    = PH_IDLE;
                        push_evt.kind = bts_pkg::EV_NF;
                        push          = 1'b1;
                    end else begin
                        phase_next = PH_TAG;
                    end
                end else if (hdr_go) begin
                    push_evt.kind = bts_pkg::EV_HDR;
                    push          = 1'b1;
                    if (hdr_last) begin
                        phase_next = PH_IDLE;
                    end else begin
                        consumed_next = hdr_sum[7:0];
                        skip_next     = s_tdata;
                        phase_next    = (s_tdata != 8'd0) ? PH_SKIP : PH_TAG;
                    end
                end else begin
                    case (phase_reg)
                        PH_OUTER_LEN: begin
                            phase_next = PH_OUTER_LEN2;
                        end
                        PH_TAG: begin
                            start_next = pos_reg;
                            tag_next   = s_tdata[6:0] & bts_pkg::TAG_MASK[6:0];
                            phase_next = PH_LEN;
                        end
                        PH_LEN: begin
                            phase_next = PH_LEN2;
                        end
                        PH_SKIP: begin
                            skip_next = skip_reg - 8'd1;
                            if (skip_reg == 8'd1) begin
                                phase_next = PH_TAG;
                            end
                        end
                        default: begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            pos_reg      <= 9'd0;
            outer_reg    <= 8'd0;
            consumed_reg <= 8'd0;
            skip_reg     <= 8'd0;
        end else begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            outer_reg    <= outer_next;
            consumed_reg <= consumed_next;
            skip_reg     <= skip_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg <= start_next;
        tag_reg   <= tag_next;
    end

    // the header that closes the outer length ends parsing
    a_last_hdr_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_evt.kind == bts_pkg::EV_HDR && push_evt.last && !s_tuser)
        |=> (phase_reg == PH_IDLE))
        else $error("front not idle after last header");

    // nothing but a new message leaves the idle phase
    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE && !(accept && s_tuser)) |=> (phase_reg == PH_IDLE))
        else $error("front left idle without start of message");

endmodule

### design/bts_queue.sv
// small event queue between the parser and the result logic
module bts_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bts_pkg::evt_t push_evt,
    output logic          q_ready,
    input  logic          pop,
    output logic          q_valid,
    output bts_pkg::evt_t q_evt
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    bts_pkg::evt_t   mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_push;
    logic            do_pop;

    assign q_ready = (cnt_reg != CntW'(DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_evt   = mem[rd_ptr_reg];
    assign do_push = push && q_ready;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CntW'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_evt;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CntW'(DEPTH))
        else $error("queue count above depth");

    a_cnt_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (cnt_reg == $past(cnt_reg) + CntW'(1)))
        else $error("queue count not advanced on push");

endmodule

### design/bts_back.sv
// match logic, configuration registers and result register
module bts_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              q_valid,
    input  bts_pkg::evt_t                     q_evt,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,  // tlv_offset, tlv_size, zero fill
    output logic [1:0]                        m_tuser   // status
);

    logic [6:0] tag_cfg_reg;
    logic [7:0] occ_cfg_reg;
    logic       merge_cfg_reg;

    logic       done_reg, done_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [8:0] mstart_reg, mstart_next;
    logic [8:0] msize_reg, msize_next;

    logic             out_valid_reg, out_valid_next;
    bts_pkg::status_t out_status_reg;
    logic [8:0]       out_off_reg;
    logic [8:0]       out_size_reg;

    logic             emit;
    bts_pkg::status_t e_status;
    logic [8:0]       e_off;
    logic [8:0]       e_size;
    logic             match;
    logic [9:0]       msum;

    assign cfg_ready = 1'b1;
    assign pop       = q_valid && (!out_valid_reg || m_tready);
    assign match     = (q_evt.tag == tag_cfg_reg);
    assign msum      = {1'b0, msize_reg} + {1'b0, q_evt.size};

    always_comb begin
        done_next   = done_reg;
        cnt_next    = cnt_reg;
        mstart_next = mstart_reg;
        msize_next  = msize_reg;
        emit        = 1'b0;
        e_status    = bts_pkg::ST_NOT_FOUND;
        e_off       = 9'd0;
        e_size      = 9'd0;

        case (q_evt.kind)
            bts_pkg::EV_SOM: begin
                done_next   = 1'b0;
                cnt_next    = 8'd0;
                mstart_next = 9'd0;
                msize_next  = 9'd0;
                if (q_evt.eom) begin
                    emit     = 1'b1;
                    e_status = bts_pkg::ST_TRUNCATED;
                end
            end
            bts_pkg::EV_HDR: begin
                if (!done_reg) begin
                    if (!merge_cfg_reg) begin
                        if (match && cnt_reg == occ_cfg_reg) begin
                            emit     = 1'b1;
                            e_status = bts_pkg::ST_FOUND;
                            e_off    = q_evt.tlv_start;
                            e_size   = q_evt.size;
                        end else begin
                            if (match) begin
                                cnt_next = cnt_reg + 8'd1;
                            end
                            if (q_evt.last) begin
                                emit = 1'b1;
                            end
                        end
                    end else begin
                        if (match) begin
                            if (cnt_reg == 8'd0) begin
                                cnt_next    = 8'd1;
                                mstart_next = q_evt.tlv_start;
                                msize_next  = q_evt.size;
                            end else begin
                                msize_next = msum[9] ? bts_pkg::MAX9 : msum[8:0];
                            end
                        end
                        if (q_evt.last) begin
                            emit = 1'b1;
                            if (cnt_next != 8'd0) begin
                                e_status = bts_pkg::ST_FOUND;
                                e_off    = mstart_next;
                                e_size   = msize_next;
                            end
                        end
                    end
                    if (!emit && q_evt.eom) begin
                        emit     = 1'b1;
                        e_status = bts_pkg::ST_TRUNCATED;
                    end
                end
            end
            bts_pkg::EV_NF: begin
                emit = !done_reg;
            end
            bts_pkg::EV_EOM: begin
                if (!done_reg && q_evt.eom) begin
                    emit     = 1'b1;
                    e_status = bts_pkg::ST_TRUNCATED;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase

        if (emit) begin
            done_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = emit;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_cfg_reg   <= 7'd0;
            occ_cfg_reg   <= 8'd0;
            merge_cfg_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                bts_pkg::CFG_SEARCH_TAG: tag_cfg_reg   <= cfg_data[6:0];
                bts_pkg::CFG_OCCURRENCE: occ_cfg_reg   <= cfg_data[7:0];
                bts_pkg::CFG_MERGE_MODE: merge_cfg_reg <= cfg_data[0];
                default: begin
                    tag_cfg_reg <= tag_cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg      <= 1'b1;
            cnt_reg       <= 8'd0;
            mstart_reg    <= 9'd0;
            msize_reg     <= 9'd0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (pop) begin
                done_reg   <= done_next;
                cnt_reg    <= cnt_next;
                mstart_reg <= mstart_next;
                msize_reg  <= msize_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && emit) begin
            out_status_reg <= e_status;
            out_off_reg    <= e_off;
            out_size_reg   <= e_size;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {6'd0, out_size_reg, out_off_reg};

    // only a found result carries an offset and size
    a_zero_unless_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != bts_pkg::ST_FOUND) |-> (m_tdata == 24'd0))
        else $error("offset or size set on a non-found result");

    // a transfer that produces a result closes the search
    a_emit_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && emit) |=> done_reg)
        else $error("search still open after a result");

endmodule

### design/ber_tlv_tag_search_unit.sv
// top level of the ber-tlv tag search unit
// Bytes of a BER-TLV message enter on the s_ channel, one per transfer:
// s_tdata is the byte, s_tuser marks the first byte of a message and
// s_tlast the last available byte. Each message gives at most one result on the
// m_ channel: m_tuser is the status (found, not found, truncated) and
// m_tdata holds the offset and size of the matching TLV or merged run.
// Search tag, occurrence and merge mode are written on the cfg channel
// (index 0, 1, 2); the user must write them only while no message is in
// flight, which the block does not enforce. cfg_ready is always high. One
// byte is taken every clock cycle while s_tready is high; the parser handles
// a byte in the cycle it is transferred, and the match logic behind the event
// queue handles one event per cycle unless a result waits for m_tready.
// When the receiver holds m_tready low, the result register keeps its
// value, the queue fills, and s_tready falls once QUEUE_DEPTH events wait.
// Reset clears the parser, the queue and the result valid flag and sets all
// configuration registers to zero; bytes before a first start are dropped.
module ber_tlv_tag_search_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // data_byte
    input  logic                           s_tlast,   // end_of_message
    input  logic                           s_tuser,   // start_of_message
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // tlv_offset, tlv_size, zero fill
    output logic [1:0]                     m_tuser,   // status
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic          q_ready;
    logic          push;
    bts_pkg::evt_t push_evt;
    logic          q_valid;
    bts_pkg::evt_t q_evt;
    logic          pop;

    bts_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_ready  (q_ready),
        .push     (push),
        .push_evt (push_evt)
    );

    bts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_evt (push_evt),
        .q_ready  (q_ready),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_evt    (q_evt)
    );

    bts_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_evt     (q_evt),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### tb/testbench.sv
// self-checking testbench for the ber-tlv tag search unit
`timescale 1ns / 100ps

module testbench;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BYTES    = 110;

    typedef enum logic [2:0] {
        P_IDLE, P_OUTER_LEN, P_OUTER_LEN2, P_TAG, P_LEN, P_LEN2, P_SKIP
    } parse_phase_t;

    typedef struct packed {
        bts_pkg::status_t status;
        logic [8:0]       offset;
        logic [8:0]       nbytes;
    } search_res_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = '0;
    logic                           s_tlast   = 1'b0;
    logic                           s_tuser   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b1;
    logic [23:0]                    m_tdata;
    logic [1:0]                     m_tuser;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bts_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // shadow registers and parser state of the predictor
    logic [6:0]   sel_tag   = '0;
    logic [7:0]   sel_occ   = '0;
    logic         sel_merge = 1'b0;
    parse_phase_t pr_phase  = P_IDLE;
    logic [8:0]   pr_pos = '0, pr_used = '0, pr_tlv_start = '0;
    logic [8:0]   pr_run_start = '0, pr_run_size = '0;
    logic [7:0]   pr_outer = '0, pr_skip = '0, pr_hits = '0;
    logic [6:0]   pr_tag  = '0;
    logic         pr_done = 1'b1;

    search_res_t  expected_q[$];
    search_res_t  want;
    logic [7:0]   msg_bytes[$];

    bit          idle_on = 1'b1;
    int unsigned mismatches, results_seen, bytes_sent, messages_sent;
    int unsigned n_found, n_not_found, n_truncated, quiet_cycles;

    ber_tlv_tag_search_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic void post_result(bts_pkg::status_t st, logic [8:0] off,
                                        logic [8:0] nb);
        search_res_t r;
        r.status = st;
        r.offset = off;
        r.nbytes = nb;
        expected_q.push_back(r);
        pr_done  = 1'b1;
        pr_phase = P_IDLE;
    endfunction

    function automatic bit close_header(logic [7:0] len, bit extra);
        logic [9:0]  tlv_bytes;
        logic [10:0] sum;
        bit          hit, last;
        tlv_bytes = {2'b00, len} + {1'b0, bts_pkg::TLV_HDR_LEN} + {9'd0, extra};
        hit  = (pr_tag == sel_tag);
        last = ({2'b00, pr_used} + {1'b0, tlv_bytes}) >= {3'b000, pr_outer};
        if (!sel_merge) begin
            if (hit) begin
                if (pr_hits == sel_occ) begin
                    post_result(bts_pkg::ST_FOUND, pr_tlv_start, tlv_bytes[8:0]);
                    return 1'b1;
                end
                pr_hits = pr_hits + 8'd1;
            end
            if (last) begin
                post_result(bts_pkg::ST_NOT_FOUND, 9'd0, 9'd0);
                return 1'b1;
            end
        end else begin
            if (hit) begin
                if (pr_hits == 8'd0) begin
                    pr_hits      = 8'd1;
                    pr_run_start = pr_tlv_start;
                    pr_run_size  = tlv_bytes[8:0];
                end else begin
                    sum = {2'b00, pr_run_size} + {1'b0, tlv_bytes};
                    pr_run_size = (sum > {2'b00, bts_pkg::MAX9}) ? bts_pkg::MAX9 : sum[8:0];
                end
            end
            if (last) begin
                if (pr_hits != 8'd0)
                    post_result(bts_pkg::ST_FOUND, pr_run_start, pr_run_size);
                else
                    post_result(bts_pkg::ST_NOT_FOUND, 9'd0, 9'd0);
                return 1'b1;
            end
        end
        pr_used  = pr_used + tlv_bytes[8:0];
        pr_skip  = len;
        pr_phase = (len != 8'd0) ? P_SKIP : P_TAG;
        return 1'b0;
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic som, logic eom);
        bit emitted;
        emitted = 1'b0;
        if (som) begin
            pr_done      = 1'b0;
            pr_phase     = P_OUTER_LEN;
            pr_pos       = '0;
            pr_outer     = '0;
            pr_used      = '0;
            pr_tlv_start = '0;
            pr_tag       = '0;
            pr_skip      = '0;
            pr_hits      = '0;
            pr_run_start = '0;
            pr_run_size  = '0;
        end else begin
            if (pr_done)
                return;
            case (pr_phase)
                P_OUTER_LEN, P_OUTER_LEN2: begin
                    if (pr_phase == P_OUTER_LEN && b == bts_pkg::LONG_LEN_MARK) begin
                        pr_phase = P_OUTER_LEN2;
                    end else begin
                        pr_outer = b;
                        if (b == 8'd0) begin
                            post_result(bts_pkg::ST_NOT_FOUND, 9'd0, 9'd0);
                            emitted = 1'b1;
                        end else begin
                            pr_phase = P_TAG;
                        end
                    end
                end
                P_TAG: begin
                    pr_tlv_start = pr_pos;
                    pr_tag       = b[6:0];
                    pr_phase     = P_LEN;
                end
                P_LEN: begin
                    if (b == bts_pkg::LONG_LEN_MARK)
                        pr_phase = P_LEN2;
                    else
                        emitted = close_header(b, 1'b0);
                end
                P_LEN2: emitted = close_header(b, 1'b1);
                P_SKIP: begin
                    pr_skip = pr_skip - 8'd1;
                    if (pr_skip == 8'd0)
                        pr_phase = P_TAG;
                end
                default: begin
                    pr_phase = P_IDLE;
                    pr_done  = 1'b1;
                end
            endcase
        end
        if (pr_pos != bts_pkg::MAX9)
            pr_pos = pr_pos + 9'd1;
        if (!emitted && eom && !pr_done)
            post_result(bts_pkg::ST_TRUNCATED, 9'd0, 9'd0);
    endfunction

    task automatic report_mismatch(input string field, input int got, input int wanted);
        mismatches++;
        $display("%0t mismatch in %s of result %0d: got %0d, want %0d",
                 $realtime, field, results_seen, got, wanted);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic som, input logic eom);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= som;
        s_tlast  <= eom;
        do @(posedge aclk); while (!s_tready);
        predict_byte(b, som, eom);
        bytes_sent++;
    endtask

    task automatic send_msg(input bit with_end);
        for (int i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == 0, with_end && (i == msg_bytes.size() - 1));
        messages_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [bts_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bts_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            bts_pkg::CFG_SEARCH_TAG: sel_tag   = val[6:0];
            bts_pkg::CFG_OCCURRENCE: sel_occ   = val;
            bts_pkg::CFG_MERGE_MODE: sel_merge = val[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [6:0] tag, input logic [7:0] occ, input logic merge);
        drain();
        write_reg(bts_pkg::CFG_SEARCH_TAG, {1'($urandom_range(0, 1)), tag});
        write_reg(bts_pkg::CFG_OCCURRENCE, occ);
        write_reg(bts_pkg::CFG_MERGE_MODE, {7'd0, merge});
    endtask

    // random well-formed messages with noise, cut-off and restarted ones mixed in
    task automatic run_random_phase(input int merge_sel);
        int unsigned sent, outer_len, used, vlen, kind, cut;
        logic [6:0]  tag;
        logic [7:0]  occ, tag_byte;
        bit          with_end;
        case ($urandom_range(0, 3))
            0: tag = 7'd0;
            1: tag = 7'h7F;
            default: tag = 7'($urandom_range(0, 127));
        endcase
        case ($urandom_range(0, 7))
            0: occ = 8'hFF;
            1: occ = 8'($urandom_range(0, 255));
            default: occ = 8'($urandom_range(0, 2));
        endcase
        configure(tag, occ, (merge_sel == 2) ? 1'($urandom_range(0, 1)) : 1'(merge_sel));
        sent = 0;
        while (sent < PHASE_BYTES) begin
            msg_bytes = {};
            msg_bytes.push_back(8'($urandom_range(0, 255)));
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                repeat ($urandom_range(0, 20)) msg_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                outer_len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(1, 24);
                if (outer_len == bts_pkg::LONG_LEN_MARK || $urandom_range(0, 3) == 0)
                    msg_bytes.push_back(bts_pkg::LONG_LEN_MARK);
                msg_bytes.push_back(8'(outer_len));
                used = 0;
                while (used < outer_len) begin
                    tag_byte = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 1))
                        tag_byte[6:0] = sel_tag;
                    msg_bytes.push_back(tag_byte);
                    vlen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(0, 6);
                    if (vlen == bts_pkg::LONG_LEN_MARK || $urandom_range(0, 4) == 0) begin
                        msg_bytes.push_back(bts_pkg::LONG_LEN_MARK);
                        used += 1;
                    end
                    msg_bytes.push_back(8'(vlen));
                    used += vlen + 2;
                    if (used < outer_len)
                        repeat (vlen) msg_bytes.push_back(8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(0, 4)) msg_bytes.push_back(8'($urandom_range(0, 255)));
                if (kind < 20) begin
                    cut = $urandom_range(0, msg_bytes.size() - 1);
                    while (msg_bytes.size() > cut + 1) void'(msg_bytes.pop_back());
                end
            end
            with_end = (kind < 94);
            sent += msg_bytes.size();
            if (sent >= PHASE_BYTES)
                with_end = 1'b1;
            send_msg(with_end);
            if (with_end && $urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_ignored_and_empty();
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b0);
        msg_bytes = {8'h70};
        send_msg(1'b1);
        msg_bytes = {8'h70, 8'h00};
        send_msg(1'b1);
        msg_bytes = {8'hFF, 8'h81, 8'h00};
        send_msg(1'b1);
    endtask

    task automatic test_single_search();
        msg_bytes = {8'h70, 8'h04, 8'h80, 8'h02, 8'hAA, 8'hBB};
        send_msg(1'b1);
        configure(7'h7F, 8'd1, 1'b0);
        msg_bytes = {8'h70, 8'h81, 8'h0A, 8'h7F, 8'h00, 8'hFF, 8'h01, 8'h11,
                     8'h7F, 8'h81, 8'h02, 8'h22, 8'h33};
        send_msg(1'b1);
        configure(7'h7F, 8'hFF, 1'b0);
        send_msg(1'b1);
    endtask

    task automatic test_merged_search();
        configure(7'h7F, 8'd0, 1'b1);
        send_msg(1'b1);
        configure(7'h05, 8'd0, 1'b1);
        send_msg(1'b1);
        configure(7'h01, 8'd0, 1'b1);
        msg_bytes = {8'h70, 8'h81, 8'hFF, 8'h01, 8'h81, 8'hFB};
        repeat (251) msg_bytes.push_back(8'($urandom_range(0, 255)));
        msg_bytes.push_back(8'h81);
        msg_bytes.push_back(8'h81);
        msg_bytes.push_back(8'hFF);
        send_msg(1'b1);
    endtask

    task automatic test_truncate_and_restart();
        msg_bytes = {8'h70, 8'h10, 8'h05, 8'h03, 8'h01};
        send_msg(1'b1);
        msg_bytes = {8'h70, 8'h20, 8'h01, 8'h05};
        send_msg(1'b0);
        msg_bytes = {8'h70, 8'h02, 8'h01, 8'h00};
        send_msg(1'b1);
        send_byte(8'h55, 1'b0, 1'b1);
        send_byte(8'h66, 1'b0, 1'b0);
    endtask

    task automatic test_random_single();
        repeat (4) run_random_phase(0);
    endtask

    task automatic test_random_merged();
        repeat (4) run_random_phase(1);
    endtask

    task automatic test_random_mixed();
        repeat (2) run_random_phase(2);
        drain();
        idle_on = 1'b0;
        repeat (2) run_random_phase(2);
    endtask

    initial begin
        @(posedge aclk);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    // outputs are stable between edges, so the transfer at the next rising edge is checked here
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch("presence", 1, 0);
            end else begin
                want = expected_q.pop_front();
                case (want.status)
                    bts_pkg::ST_FOUND:     n_found++;
                    bts_pkg::ST_NOT_FOUND: n_not_found++;
                    default:               n_truncated++;
                endcase
                if (m_tuser !== want.status)
                    report_mismatch("status", m_tuser, want.status);
                if (m_tdata[8:0] !== want.offset)
                    report_mismatch("tlv_offset", m_tdata[8:0], want.offset);
                if (m_tdata[17:9] !== want.nbytes)
                    report_mismatch("tlv_size", m_tdata[17:9], want.nbytes);
                if (m_tdata[23:18] !== 6'd0)
                    report_mismatch("zero fill", m_tdata[23:18], 0);
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_ignored_and_empty();
        test_single_search();
        test_merged_search();
        test_truncate_and_restart();
        test_random_single();
        test_random_merged();
        test_random_mixed();
        drain();
        $display("sent %0d bytes in %0d messages, checked %0d results",
                 bytes_sent, messages_sent, results_seen);
        $display("results by status: %0d found, %0d not found, %0d truncated, %0d mismatches",
                 n_found, n_not_found, n_truncated, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
